FILE: rtl/pape_pkg.sv
// ----------------------------------------------------------------------------
// pape_pkg
// Types and constants shared by the polygon area and perimeter engine.
// ----------------------------------------------------------------------------
package pape_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int ADDR_BITS    = 8;
    localparam int COORD_BITS   = 24;
    localparam int COUNT_BITS   = 9;
    localparam int TOL_BITS     = 20;
    localparam int AREA_BITS    = 57;
    localparam int PERIM_BITS   = 42;
    localparam int RAD_BITS     = 66;   // squared length scaled by 2^16
    localparam int ROOT_BITS    = 33;

    // operation codes
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_POP   = 3'd1;
    localparam logic [2:0] OP_CLEAR = 3'd2;
    localparam logic [2:0] OP_DUP   = 3'd3;
    localparam logic [2:0] OP_CALC  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]                    operation;
        logic signed [COORD_BITS-1:0]  x_coord;
        logic signed [COORD_BITS-1:0]  y_coord;
    } t_in_word;

    typedef struct packed {
        logic [1:0]            status;
        logic                  is_duplicate;
        logic [COUNT_BITS-1:0] vertex_count;
        logic [AREA_BITS-1:0]  area_doubled;
        logic [PERIM_BITS-1:0] perimeter;
    } t_out_word;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_vertex;

endpackage

FILE: rtl/pape_vmem.sv
// ----------------------------------------------------------------------------
// pape_vmem
// Vertex store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pape_vmem (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [pape_pkg::ADDR_BITS-1:0] i_wr_addr,
    input  pape_pkg::t_vertex            i_wr_data,
    input  logic                         i_rd_en,
    input  logic [pape_pkg::ADDR_BITS-1:0] i_rd_addr,
    output pape_pkg::t_vertex            o_rd_data
);

    pape_pkg::t_vertex r_mem [pape_pkg::MAX_VERTICES];
    pape_pkg::t_vertex r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/pape_sqrt.sv
// ----------------------------------------------------------------------------
// pape_sqrt
// Integer square root, restoring method, one root bit per cycle.
// ----------------------------------------------------------------------------
module pape_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pape_pkg::RAD_BITS-1:0] i_radicand,
    output logic                          o_done,
    output logic [pape_pkg::ROOT_BITS-1:0] o_root
);

    localparam int REM_BITS = pape_pkg::ROOT_BITS + 2;

    logic                           r_busy;
    logic                           r_done;
    logic [5:0]                     r_cnt;
    logic [pape_pkg::RAD_BITS-1:0]  r_rad;
    logic [REM_BITS-1:0]            r_rem;
    logic [pape_pkg::ROOT_BITS-1:0] r_root;

    logic [REM_BITS-1:0] rem_sh;
    logic [REM_BITS-1:0] trial;
    logic                take;

    // bring down two radicand bits, try root*4+1
    assign rem_sh = {r_rem[REM_BITS-3:0], r_rad[pape_pkg::RAD_BITS-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= 6'(pape_pkg::ROOT_BITS - 1);
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 6'd1;
            r_rad  <= {r_rad[pape_pkg::RAD_BITS-3:0], 2'b00};
            r_rem  <= take ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[pape_pkg::ROOT_BITS-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: rtl/polygon_area_perimeter_engine_unit.sv
// ----------------------------------------------------------------------------
// polygon_area_perimeter_engine_unit
// Vertex list with push/pop/clear, duplicate check and shoelace area plus
// perimeter over the closed polygon.
//
//   channel  dir  signals                          word
//   in       in   i_in_valid / o_in_ready          pape_pkg::t_in_word
//   out      out  o_out_valid / i_out_ready        pape_pkg::t_out_word
//   cfg      in   i_cfg_valid / o_cfg_ready        tolerance_squared, 20 bit
//
// Push, pop, clear and unused codes finish in idle; words may follow back to
// back. Duplicate check does one vertex memory read per stored vertex and stops
// at the first near match or the last vertex. Calculate runs the bit-serial square
// root on each edge. Input stalls while an operation runs or a result waits.
// Synchronous active-low reset; the vertex memory needs no clearing.
// ----------------------------------------------------------------------------
module polygon_area_perimeter_engine_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pape_pkg::t_in_word    i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pape_pkg::t_out_word   o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [pape_pkg::TOL_BITS-1:0] i_cfg_data
);

    localparam int CB = pape_pkg::COORD_BITS;
    localparam int AB = pape_pkg::ADDR_BITS;
    localparam int NB = pape_pkg::COUNT_BITS;
    localparam int ACC_BITS = 61;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DUP   = 3'd1;
    localparam logic [2:0] S_FIRST = 3'd2;
    localparam logic [2:0] S_EDGE  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_SQRT  = 3'd6;
    localparam logic [2:0] S_AREA  = 3'd7;

    logic [2:0]                   r_state, n_state;
    logic [NB-1:0]                r_count, n_count;
    logic signed [CB-1:0]         r_base_y;
    logic [pape_pkg::TOL_BITS-1:0] r_tol;
    logic signed [CB-1:0]         r_qx, r_qy;
    logic [AB-1:0]                r_idx;
    logic [NB-1:0]                r_edge;
    logic signed [CB-1:0]         r_px, r_py;
    logic signed [CB:0]           r_dx, r_dy;
    logic signed [CB+1:0]         r_h;
    logic [2*CB+1:0]              r_sqx, r_sqy;
    logic [2*CB+2:0]              r_prod;
    logic                         r_neg;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic [pape_pkg::PERIM_BITS-1:0] r_perim;
    logic                         r_out_valid;
    pape_pkg::t_out_word          r_out;

    logic                         acc_in;
    logic                         wr_en, rd_en;
    logic [AB-1:0]                rd_addr;
    pape_pkg::t_vertex            wr_data, rd_data;
    logic                         sq_start, sq_done;
    logic [pape_pkg::ROOT_BITS-1:0] sq_root;
    logic [pape_pkg::RAD_BITS-1:0] sq_rad;

    logic signed [CB:0]           q_dx, q_dy, e_dx, e_dy, d_py, d_cy;
    logic [CB:0]                  q_ax, q_ay, m_dx, m_dy;
    logic [CB+1:0]                m_h;
    logic [pape_pkg::TOL_BITS:0]  q_dist;
    logic                         q_near;
    logic                         dup_last;
    logic [2*CB+2:0]              sq_sum;
    logic [pape_pkg::PERIM_BITS:0] perim_sum;
    logic [ACC_BITS-1:0]          area_mag;
    logic                         last_edge;
    logic [NB-1:0]                next_edge;
    logic [1:0]                   idle_status;

    assign acc_in      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // vertex store
    assign wr_en   = acc_in && i_in_word.operation == pape_pkg::OP_PUSH
                     && r_count < NB'(pape_pkg::MAX_VERTICES);
    assign wr_data = '{x: i_in_word.x_coord, y: i_in_word.y_coord};

    pape_vmem u_vmem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AB-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // edge square root
    pape_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_rad),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // status of a word accepted in idle
    assign idle_status = (i_in_word.operation == pape_pkg::OP_PUSH
                          && r_count >= NB'(pape_pkg::MAX_VERTICES)) ? pape_pkg::ST_FULL
                       : (i_in_word.operation == pape_pkg::OP_POP && r_count == '0)
                         ? pape_pkg::ST_EMPTY : pape_pkg::ST_OK;

    // duplicate check datapath
    assign q_dx   = {rd_data.x[CB-1], rd_data.x} - {r_qx[CB-1], r_qx};
    assign q_dy   = {rd_data.y[CB-1], rd_data.y} - {r_qy[CB-1], r_qy};
    assign q_ax   = q_dx[CB] ? (CB+1)'(-q_dx) : q_dx;
    assign q_ay   = q_dy[CB] ? (CB+1)'(-q_dy) : q_dy;
    assign q_dist = (pape_pkg::TOL_BITS+1)'(q_ax[9:0] * q_ax[9:0])
                  + (pape_pkg::TOL_BITS+1)'(q_ay[9:0] * q_ay[9:0]);
    assign q_near = q_ax < (CB+1)'(1024) && q_ay < (CB+1)'(1024)
                    && q_dist < {1'b0, r_tol};
    assign dup_last = ({1'b0, r_idx} == r_count - NB'(1));

    // edge terms
    assign e_dx = {rd_data.x[CB-1], rd_data.x} - {r_px[CB-1], r_px};
    assign e_dy = {rd_data.y[CB-1], rd_data.y} - {r_py[CB-1], r_py};
    assign d_py = {r_py[CB-1], r_py} - {r_base_y[CB-1], r_base_y};
    assign d_cy = {rd_data.y[CB-1], rd_data.y} - {r_base_y[CB-1], r_base_y};
    assign m_dx = r_dx[CB] ? (CB+1)'(-r_dx) : r_dx;
    assign m_dy = r_dy[CB] ? (CB+1)'(-r_dy) : r_dy;
    assign m_h  = r_h[CB+1] ? (CB+2)'(-r_h) : r_h;

    assign sq_sum    = (2*CB+3)'(r_sqx) + (2*CB+3)'(r_sqy);
    assign sq_rad    = {sq_sum[2*CB+1:0], 16'd0};
    assign sq_start  = (r_state == S_ACC);
    assign perim_sum = (pape_pkg::PERIM_BITS+1)'(r_perim)
                     + (pape_pkg::PERIM_BITS+1)'(sq_root);
    assign last_edge = (r_edge == r_count);
    assign next_edge = r_edge + NB'(1);
    assign area_mag  = r_acc[ACC_BITS-1] ? ACC_BITS'(-r_acc) : ACC_BITS'(r_acc);

    // memory read requests
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (acc_in && ((i_in_word.operation == pape_pkg::OP_DUP
                                && r_count != '0)
                            || (i_in_word.operation == pape_pkg::OP_CALC
                                && r_count >= NB'(3)))) begin
                    rd_en = 1'b1;
                end
            end
            S_DUP: begin
                rd_en   = 1'b1;
                rd_addr = r_idx + AB'(1);
            end
            S_FIRST: begin
                rd_en   = 1'b1;
                rd_addr = AB'(1);
            end
            S_SQRT: begin
                if (sq_done && !last_edge) begin
                    rd_en   = 1'b1;
                    rd_addr = (next_edge == r_count) ? '0 : next_edge[AB-1:0];
                end
            end
            default: ;
        endcase
    end

    // next state and count
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    case (i_in_word.operation)
                        pape_pkg::OP_PUSH:
                            if (r_count < NB'(pape_pkg::MAX_VERTICES))
                                n_count = r_count + NB'(1);
                        pape_pkg::OP_POP:
                            if (r_count != '0) n_count = r_count - NB'(1);
                        pape_pkg::OP_CLEAR: n_count = '0;
                        pape_pkg::OP_DUP:
                            if (r_count != '0) n_state = S_DUP;
                        pape_pkg::OP_CALC:
                            if (r_count >= NB'(3)) n_state = S_FIRST;
                        default: ;
                    endcase
                end
            end
            S_DUP:   if (q_near || dup_last) n_state = S_IDLE;
            S_FIRST: n_state = S_EDGE;
            S_EDGE:  n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = S_SQRT;
            S_SQRT:  if (sq_done) n_state = last_edge ? S_AREA : S_EDGE;
            S_AREA:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_base_y    <= '0;
            r_tol       <= pape_pkg::TOL_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid) r_tol <= i_cfg_data;
            if (wr_en && r_count == '0) r_base_y <= i_in_word.y_coord;
            if ((acc_in && n_state == S_IDLE)
                || (r_state == S_DUP && n_state == S_IDLE)
                || r_state == S_AREA) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath and result word
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (acc_in) begin
                    r_qx    <= i_in_word.x_coord;
                    r_qy    <= i_in_word.y_coord;
                    r_idx   <= '0;
                    r_acc   <= '0;
                    r_perim <= '0;
                    r_out   <= '{status: idle_status, is_duplicate: 1'b0,
                                 vertex_count: n_count, area_doubled: '0,
                                 perimeter: '0};
                end
            end
            S_DUP: begin
                r_idx <= r_idx + AB'(1);
                if (q_near) r_out.is_duplicate <= 1'b1;
            end
            S_FIRST: begin
                r_px   <= rd_data.x;
                r_py   <= rd_data.y;
                r_edge <= NB'(1);
            end
            S_EDGE: begin
                r_dx <= e_dx;
                r_dy <= e_dy;
                r_h  <= {d_py[CB], d_py} + {d_cy[CB], d_cy};
                r_px <= rd_data.x;
                r_py <= rd_data.y;
            end
            S_MUL: begin
                r_sqx  <= m_dx * m_dx;
                r_sqy  <= m_dy * m_dy;
                r_prod <= m_dx * m_h;
                r_neg  <= r_dx[CB] != r_h[CB+1];
            end
            S_ACC: begin
                if (r_neg) r_acc <= r_acc - $signed(ACC_BITS'(r_prod));
                else       r_acc <= r_acc + $signed(ACC_BITS'(r_prod));
            end
            S_SQRT: begin
                if (sq_done) begin
                    r_perim <= perim_sum[pape_pkg::PERIM_BITS]
                               ? '1 : perim_sum[pape_pkg::PERIM_BITS-1:0];
                    r_edge  <= next_edge;
                end
            end
            S_AREA: begin
                r_out.area_doubled <= (|area_mag[ACC_BITS-1:pape_pkg::AREA_BITS])
                                      ? '1 : area_mag[pape_pkg::AREA_BITS-1:0];
                r_out.perimeter    <= r_perim;
            end
            default: ;
        endcase
    end

endmodule

FILE: tb/polygon_area_perimeter_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// polygon_area_perimeter_engine_unit_tb
// Self-checking bench for the polygon area and perimeter engine. Vertex
// lists are built with push/pop/clear, queried for duplicates and measured.
// Every result word is compared against a local predictor of the vertex
// list, shoelace area and floored edge lengths. Both handshakes see random
// stalls, and the tolerance register is swept between phases.
// ----------------------------------------------------------------------------
module polygon_area_perimeter_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pape_pkg::*;

    // unused operation codes, expected to leave the list alone
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [63:0] AREA_SAT  = (64'd1 << AREA_BITS) - 64'd1;
    localparam logic [63:0] PERIM_SAT = (64'd1 << PERIM_BITS) - 64'd1;
    localparam longint      COORD_MIN = -(64'sd1 <<< (COORD_BITS - 1));
    localparam longint      COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    t_in_word            in_word;
    logic                out_valid;
    logic                out_ready;
    t_out_word           out_word;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [TOL_BITS-1:0] cfg_data;

    // predictor state
    longint              list_x [MAX_VERTICES];
    longint              list_y [MAX_VERTICES];
    int                  list_len;
    longint              base_y;
    logic [TOL_BITS-1:0] tol_sq;

    t_out_word           pending_q [$];
    t_out_word           head_w;
    bit                  steady;
    int                  mismatches;
    int                  words_sent;
    int                  n_calc;
    int                  n_dup_hits;
    int                  n_full;
    int                  n_tol_writes;

    polygon_area_perimeter_engine_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // floor(256 * sqrt(dx^2 + dy^2)), bit-serial
    function automatic logic [63:0] edge_root(input longint dx, input longint dy);
        logic [127:0] sq;
        logic [127:0] root;
        logic [127:0] trial;
        sq   = (128'(dx * dx) + 128'(dy * dy)) << 16;
        root = '0;
        for (int b = 40; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= sq) root = trial;
        end
        return root[63:0];
    endfunction

    // expected result of one word; updates the predicted list
    function automatic t_out_word predict_word(input t_in_word w);
        t_out_word        r;
        longint           x;
        longint           y;
        longint           dx;
        longint           h;
        longint           ax;
        longint           ay;
        longint           prod;
        logic signed [127:0] acc;
        logic [63:0]      per;
        int               j;
        r = '0;
        x = w.x_coord;
        y = w.y_coord;
        case (w.operation)
            OP_PUSH: begin
                if (list_len >= MAX_VERTICES) begin
                    r.status = ST_FULL;
                end else begin
                    if (list_len == 0) base_y = y;
                    list_x[list_len] = x;
                    list_y[list_len] = y;
                    list_len++;
                end
            end
            OP_POP: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            OP_CLEAR: list_len = 0;
            OP_DUP: begin
                for (int i = 0; i < list_len; i++) begin
                    ax = list_x[i] - x;
                    ay = list_y[i] - y;
                    if (ax < 0) ax = -ax;
                    if (ay < 0) ay = -ay;
                    if (ax < 1024 && ay < 1024 && ax * ax + ay * ay < longint'(tol_sq))
                        r.is_duplicate = 1'b1;
                end
            end
            OP_CALC: begin
                if (list_len >= 3) begin
                    acc = '0;
                    per = '0;
                    for (int i = 0; i < list_len; i++) begin
                        j    = (i + 1 == list_len) ? 0 : i + 1;
                        dx   = list_x[j] - list_x[i];
                        h    = (list_y[i] - base_y) + (list_y[j] - base_y);
                        prod = dx * h;
                        acc  = acc + prod;
                        per  = per + edge_root(dx, list_y[j] - list_y[i]);
                        if (per > PERIM_SAT) per = PERIM_SAT;
                    end
                    if (acc < 0) acc = -acc;
                    r.area_doubled = (acc > AREA_SAT) ? AREA_SAT[AREA_BITS-1:0]
                                                      : acc[AREA_BITS-1:0];
                    r.perimeter    = per[PERIM_BITS-1:0];
                end
            end
            default: ;
        endcase
        r.vertex_count = list_len[COUNT_BITS-1:0];
        return r;
    endfunction

    function automatic void flag(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_q.size() == 0) begin
                flag($sformatf("unexpected result word %p", out_word));
            end else begin
                head_w = pending_q.pop_front();
                if (out_word.status !== head_w.status ||
                    out_word.is_duplicate !== head_w.is_duplicate ||
                    out_word.vertex_count !== head_w.vertex_count ||
                    out_word.area_doubled !== head_w.area_doubled ||
                    out_word.perimeter !== head_w.perimeter)
                    flag($sformatf("exp st=%0d dup=%0d cnt=%0d area=%0d per=%0d, got st=%0d dup=%0d cnt=%0d area=%0d per=%0d",
                        head_w.status, head_w.is_duplicate, head_w.vertex_count,
                        head_w.area_doubled, head_w.perimeter,
                        out_word.status, out_word.is_duplicate, out_word.vertex_count,
                        out_word.area_doubled, out_word.perimeter));
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) out_ready <= steady || ($urandom_range(99) >= 15);

    // one input word through the handshake
    task automatic send_word(input logic [2:0] op, input longint x, input longint y);
        t_in_word  w;
        t_out_word e;
        int        gap;
        w.operation = op;
        w.x_coord   = x[COORD_BITS-1:0];
        w.y_coord   = y[COORD_BITS-1:0];
        if (!steady && $urandom_range(99) < 15) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 2);
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        e = predict_word(w);
        pending_q.insert(pending_q.size(), e);
        words_sent++;
        if (op == OP_CALC) n_calc++;
        if (e.is_duplicate) n_dup_hits++;
        if (e.status == ST_FULL) n_full++;
    endtask

    // stop sending and let every outstanding result drain
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_tol(input logic [TOL_BITS-1:0] v);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        tol_sq = v;
        n_tol_writes++;
    endtask

    function automatic longint rand_coord(input int mode);
        longint v;
        case (mode)
            0: v = longint'($urandom_range(2000)) - 1000;
            1: begin
                v = longint'($urandom() & 32'hFF_FFFF);
                if (v > COORD_MAX) v = v - (64'sd1 <<< COORD_BITS);
            end
            default: begin
                case ($urandom_range(3))
                    0: v = COORD_MIN;
                    1: v = COORD_MAX;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [TOL_BITS-1:0] pick_tol();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return TOL_BITS'($urandom_range(1, 64));
            3: return TOL_BITS'($urandom_range(65, 3000));
            default: return TOL_BITS'($urandom());
        endcase
    endfunction

    // a query near a stored vertex, or anywhere if the list is empty
    task automatic probe_near(input int spread);
        int k;
        if (list_len == 0) begin
            send_word(OP_DUP, rand_coord(0), rand_coord(0));
        end else begin
            k = $urandom_range(list_len - 1);
            send_word(OP_DUP,
                      list_x[k] + $urandom_range(2 * spread) - spread,
                      list_y[k] + $urandom_range(2 * spread) - spread);
        end
    endtask

    // extremes, every operation and the empty/short-list cases
    task automatic test_directed();
        send_word(OP_POP, 0, 0);
        send_word(OP_DUP, 0, 0);
        send_word(OP_CALC, 0, 0);
        send_word(OP_PUSH, COORD_MIN, COORD_MIN);
        send_word(OP_CALC, 0, 0);
        send_word(OP_PUSH, COORD_MAX, COORD_MIN);
        send_word(OP_CALC, 0, 0);
        send_word(OP_PUSH, COORD_MAX, COORD_MAX);
        send_word(OP_CALC, 0, 0);
        send_word(OP_PUSH, COORD_MIN, COORD_MAX);
        send_word(OP_CALC, 0, 0);
        send_word(OP_DUP, COORD_MAX, COORD_MAX);
        send_word(OP_DUP, COORD_MAX - 1, COORD_MAX);
        send_word(OP_SPARE_5, COORD_MAX, -1);
        send_word(OP_SPARE_6, -1, COORD_MIN);
        send_word(OP_SPARE_7, 0, 0);
        send_word(OP_POP, 0, 0);
        send_word(OP_CALC, 0, 0);
        send_word(OP_CLEAR, 0, 0);
        send_word(OP_CALC, 0, 0);
        send_word(OP_PUSH, 5, -7);
        send_word(OP_PUSH, -3, 9);
        send_word(OP_PUSH, 12, 4);
        send_word(OP_CALC, 0, 0);
        drain();
    endtask

    // tolerance extremes against near and exact queries
    task automatic test_tolerance();
        logic [TOL_BITS-1:0] sweep [4];
        sweep = '{'0, TOL_BITS'(1), TOL_BITS'(50), '1};
        foreach (sweep[s]) begin
            write_tol(sweep[s]);
            send_word(OP_DUP, 5, -7);
            send_word(OP_DUP, 10, -2);
            send_word(OP_DUP, 5 + 1023, -7);
            send_word(OP_DUP, 5 + 1024, -7);
            for (int i = 0; i < 3; i++) probe_near(8);
        end
        write_tol(TOL_BITS'(1));
    endtask

    // fill to capacity, overflow, then measure the full list
    task automatic test_full_list();
        send_word(OP_CLEAR, 0, 0);
        for (int i = 0; i < MAX_VERTICES; i++)
            send_word(OP_PUSH, rand_coord(i % 3), rand_coord((i + 1) % 3));
        send_word(OP_PUSH, 1, 1);
        probe_near(0);
        send_word(OP_CALC, 0, 0);
        send_word(OP_POP, 0, 0);
        send_word(OP_PUSH, COORD_MAX, COORD_MIN);
        send_word(OP_CALC, 0, 0);
        send_word(OP_CLEAR, 0, 0);
        drain();
    endtask

    // random polygons, queries and noise
    task automatic test_random(input int quota);
        int stop_at;
        int seq;
        int kind;
        int n;
        int mode;
        stop_at = words_sent + quota;
        seq = 0;
        while (words_sent < stop_at) begin
            if (seq % 9 == 8) write_tol(pick_tol());
            steady = (seq >= 40 && seq < 70);
            kind = $urandom_range(99);
            if (kind < 70) begin
                send_word(OP_CLEAR, 0, 0);
                case ($urandom_range(19))
                    0:       n = $urandom_range(2);
                    1, 2:    n = $urandom_range(13, 60);
                    default: n = $urandom_range(3, 12);
                endcase
                mode = ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 2);
                for (int i = 0; i < n; i++) send_word(OP_PUSH, rand_coord(mode), rand_coord(mode));
                repeat ($urandom_range(3)) probe_near($urandom_range(40));
                send_word(OP_CALC, 0, 0);
                if ($urandom_range(1)) begin
                    repeat ($urandom_range(1, 2)) send_word(OP_POP, 0, 0);
                    send_word(OP_CALC, 0, 0);
                end
            end else if (kind < 85) begin
                repeat ($urandom_range(1, 5)) probe_near($urandom_range(1, 60));
            end else begin
                repeat ($urandom_range(1, 6))
                    send_word(3'($urandom_range(7)), rand_coord($urandom_range(2)),
                              rand_coord($urandom_range(2)));
            end
            seq++;
        end
        steady = 1'b0;
        drain();
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        out_ready <= 1'b1;
        steady    = 1'b0;
        list_len  = 0;
        base_y    = 0;
        tol_sq    = TOL_BITS'(1);
        mismatches = 0;
        words_sent = 0;
        n_calc = 0;
        n_dup_hits = 0;
        n_full = 0;
        n_tol_writes = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_tolerance();
        test_full_list();
        test_random(1500);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d words: %0d area/perimeter runs, %0d duplicate hits, %0d full-list pushes,",
                 words_sent, n_calc, n_dup_hits, n_full);
        $display("%0d tolerance writes; %0d mismatches.", n_tol_writes, mismatches);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("Timeout with %0d results outstanding", pending_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pape_pkg.sv
rtl/pape_vmem.sv
rtl/pape_sqrt.sv
rtl/polygon_area_perimeter_engine_unit.sv
tb/polygon_area_perimeter_engine_unit_tb.sv
